/* rtl/frs_pkg.sv */
// Package for the Schlick Fresnel reflectance block: shared types and constants.
// No dependencies.
package frs_pkg;

  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int DIV_STAGES  = 31;
  localparam int SQRT_STAGES = 16;
  localparam int POW_STEPS   = 4;

  localparam logic [15:0] ONE_Q15 = 16'h8000;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic        bad;
    logic        tir;
    logic        gt;
    logic [15:0] c;
  } frs_tag_t;

  typedef struct packed {
    frs_tag_t    tag;
    logic [62:0] num_s;
    logic [33:0] den_s;
    logic [62:0] num_r;
    logic [33:0] den_r;
  } frs_job_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [30:0] lo;
    logic [30:0] q;
    logic [33:0] den;
  } frs_dlane_t;

  typedef struct packed {
    frs_tag_t    tag;
    logic [30:0] quo_s;
    logic [30:0] quo_r;
  } frs_quo_t;

  typedef struct packed {
    frs_tag_t    tag;
    logic [15:0] r0;
    logic [15:0] ct;
  } frs_root_t;

endpackage

/* rtl/frs_front.sv */
// Front end: takes requests, forms the dot product, squares and the TIR test,
// and emits division jobs. Depends on frs_pkg.
module frs_front import frs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_eye_x,
  input  logic signed [15:0] in_eye_y,
  input  logic signed [15:0] in_eye_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic        [15:0] in_index_from,
  input  logic        [15:0] in_index_to,
  input  logic               q_full,
  output logic               job_valid,
  output frs_job_t           job
);

  logic adv;
  logic [6:1] v_r;

  logic signed [31:0] p0_r, p1_r, p2_r;
  logic [31:0] n1sq1_r, n2sq1_r, dsq1_r;
  logic [16:0] ssum1_r;
  logic        bad1_r, gt1_r;

  logic [15:0] c2_r;
  logic [33:0] sumsq2_r;
  logic [31:0] n1sq2_r, n2sq2_r, dsq2_r;
  logic        bad2_r, gt2_r;

  logic [30:0] omc3_r;
  logic [15:0] c3_r;
  logic [33:0] sumsq3_r;
  logic [31:0] n1sq3_r, n2sq3_r, dsq3_r;
  logic        bad3_r, gt3_r;

  logic [47:0] pa4_r;
  logic [46:0] pb4_r;
  logic [15:0] c4_r;
  logic [33:0] sumsq4_r;
  logic [31:0] n2sq4_r, dsq4_r;
  logic        bad4_r, gt4_r;

  logic [62:0] lhs5_r;
  logic [15:0] c5_r;
  logic [33:0] sumsq5_r;
  logic [31:0] n2sq5_r, dsq5_r;
  logic        bad5_r, gt5_r;

  frs_job_t job_r, job_nxt;

  logic signed [33:0] dot;
  logic [15:0]        c_nxt;
  logic [31:0]        csq;
  logic               tir;
  logic               use_s;

  assign adv  = !q_full;
  assign busy = q_full;

  always_comb begin
    dot = 34'(p0_r) + 34'(p1_r) + 34'(p2_r);
    if (dot <= 34'sd0) begin
      c_nxt = '0;
    end else if (dot > 34'sd268435456) begin
      c_nxt = ONE_Q15;
    end else begin
      c_nxt = dot[28:13];
    end
    csq = c2_r * c2_r;
  end

  always_comb begin
    tir   = gt5_r && (lhs5_r > {1'b0, n2sq5_r, 30'b0});
    use_s = gt5_r && !tir && (n2sq5_r != '0);
    job_nxt.tag.bad = bad5_r;
    job_nxt.tag.tir = tir;
    job_nxt.tag.gt  = gt5_r;
    job_nxt.tag.c   = c5_r;
    job_nxt.num_s   = use_s ? lhs5_r : '0;
    job_nxt.den_s   = use_s ? 34'(n2sq5_r) : 34'd1;
    job_nxt.num_r   = bad5_r ? '0 : {16'b0, dsq5_r, 15'b0};
    job_nxt.den_r   = bad5_r ? 34'd1 : sumsq5_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:1], start};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p0_r    <= in_eye_x * in_norm_x;
      p1_r    <= in_eye_y * in_norm_y;
      p2_r    <= in_eye_z * in_norm_z;
      n1sq1_r <= in_index_from * in_index_from;
      n2sq1_r <= in_index_to * in_index_to;
      dsq1_r  <= (in_index_from > in_index_to)
                 ? (in_index_from - in_index_to) * (in_index_from - in_index_to)
                 : (in_index_to - in_index_from) * (in_index_to - in_index_from);
      ssum1_r <= 17'(in_index_from) + 17'(in_index_to);
      bad1_r  <= (in_index_from == '0) && (in_index_to == '0);
      gt1_r   <= in_index_from > in_index_to;

      c2_r     <= c_nxt;
      sumsq2_r <= ssum1_r * ssum1_r;
      n1sq2_r  <= n1sq1_r;
      n2sq2_r  <= n2sq1_r;
      dsq2_r   <= dsq1_r;
      bad2_r   <= bad1_r;
      gt2_r    <= gt1_r;

      omc3_r   <= ONE_Q30 - csq[30:0];
      c3_r     <= c2_r;
      sumsq3_r <= sumsq2_r;
      n1sq3_r  <= n1sq2_r;
      n2sq3_r  <= n2sq2_r;
      dsq3_r   <= dsq2_r;
      bad3_r   <= bad2_r;
      gt3_r    <= gt2_r;

      pa4_r    <= n1sq3_r * omc3_r[15:0];
      pb4_r    <= n1sq3_r * omc3_r[30:16];
      c4_r     <= c3_r;
      sumsq4_r <= sumsq3_r;
      n2sq4_r  <= n2sq3_r;
      dsq4_r   <= dsq3_r;
      bad4_r   <= bad3_r;
      gt4_r    <= gt3_r;

      lhs5_r   <= 63'(pa4_r) + {pb4_r, 16'b0};
      c5_r     <= c4_r;
      sumsq5_r <= sumsq4_r;
      n2sq5_r  <= n2sq4_r;
      dsq5_r   <= dsq4_r;
      bad5_r   <= bad4_r;
      gt5_r    <= gt4_r;

      job_r <= job_nxt;
    end
  end

  assign job_valid = v_r[6];
  assign job       = job_r;

endmodule

/* rtl/frs_fifo.sv */
// Short job queue between front and back ends.
// Depends on frs_pkg.
module frs_fifo import frs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  frs_job_t wr_data,
  output logic     full,
  output logic     rd_valid,
  output frs_job_t rd_data
);

  frs_job_t mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wp_r, rp_r;
  logic [FIFO_AW:0]   cnt_r;
  logic do_push, do_pop;

  assign full     = cnt_r == (FIFO_AW+1)'(FIFO_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign do_push  = push && !full;
  assign do_pop   = rd_valid;
  assign rd_data  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (FIFO_AW+1)'(do_push) - (FIFO_AW+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wp_r] <= wr_data;
  end

endmodule

/* rtl/frs_div.sv */
// Two-lane pipelined restoring divider, one quotient bit per stage per lane.
// Depends on frs_pkg.
module frs_div import frs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_vld,
  input  frs_job_t job,
  output logic     out_vld,
  output frs_quo_t quo
);

  logic [DIV_STAGES:0] vld_r;
  frs_dlane_t ls_r [DIV_STAGES+1];
  frs_dlane_t lr_r [DIV_STAGES+1];
  frs_tag_t   tag_r [DIV_STAGES+1];

  function automatic frs_dlane_t div_step(frs_dlane_t a);
    logic [34:0] t;
    frs_dlane_t  b;
    t = {a.rem, a.lo[30]};
    b = a;
    b.lo = {a.lo[29:0], 1'b0};
    if (t >= {1'b0, a.den}) begin
      b.rem = 34'(t - {1'b0, a.den});
      b.q   = {a.q[29:0], 1'b1};
    end else begin
      b.rem = t[33:0];
      b.q   = {a.q[29:0], 1'b0};
    end
    return b;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[DIV_STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    ls_r[0].rem <= 34'(job.num_s[62:31]);
    ls_r[0].lo  <= job.num_s[30:0];
    ls_r[0].q   <= '0;
    ls_r[0].den <= job.den_s;
    lr_r[0].rem <= 34'(job.num_r[62:31]);
    lr_r[0].lo  <= job.num_r[30:0];
    lr_r[0].q   <= '0;
    lr_r[0].den <= job.den_r;
    tag_r[0]    <= job.tag;
    for (int k = 1; k <= DIV_STAGES; k++) begin
      ls_r[k]  <= div_step(ls_r[k-1]);
      lr_r[k]  <= div_step(lr_r[k-1]);
      tag_r[k] <= tag_r[k-1];
    end
  end

  assign out_vld   = vld_r[DIV_STAGES];
  assign quo.tag   = tag_r[DIV_STAGES];
  assign quo.quo_s = ls_r[DIV_STAGES].q;
  assign quo.quo_r = lr_r[DIV_STAGES].q;

endmodule

/* rtl/frs_sqrt.sv */
// Pipelined integer square root of 1 - sin_t^2, one result bit per stage.
// Depends on frs_pkg.
module frs_sqrt import frs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_vld,
  input  frs_quo_t  quo,
  output logic      out_vld,
  output frs_root_t root
);

  logic [SQRT_STAGES:0] vld_r;
  logic [31:0] v_r   [SQRT_STAGES+1];
  logic [31:0] res_r [SQRT_STAGES+1];
  logic [15:0] r0_r  [SQRT_STAGES+1];
  frs_tag_t    tag_r [SQRT_STAGES+1];

  logic [30:0] s_sat;

  assign s_sat = (quo.quo_s > ONE_Q30) ? ONE_Q30 : quo.quo_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[SQRT_STAGES-1:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] bitv;
    logic [31:0] trial;
    v_r[0]   <= 32'(ONE_Q30 - s_sat);
    res_r[0] <= '0;
    r0_r[0]  <= (quo.quo_r > 31'(ONE_Q15)) ? ONE_Q15 : quo.quo_r[15:0];
    tag_r[0] <= quo.tag;
    for (int k = 0; k < SQRT_STAGES; k++) begin
      bitv  = 32'd1 << (30 - 2 * k);
      trial = res_r[k] + bitv;
      if (v_r[k] >= trial) begin
        v_r[k+1]   <= v_r[k] - trial;
        res_r[k+1] <= (res_r[k] >> 1) + bitv;
      end else begin
        v_r[k+1]   <= v_r[k];
        res_r[k+1] <= res_r[k] >> 1;
      end
      r0_r[k+1]  <= r0_r[k];
      tag_r[k+1] <= tag_r[k];
    end
  end

  assign out_vld  = vld_r[SQRT_STAGES];
  assign root.tag = tag_r[SQRT_STAGES];
  assign root.r0  = r0_r[SQRT_STAGES];
  assign root.ct  = (res_r[SQRT_STAGES] > 32'(ONE_Q15)) ? ONE_Q15
                                                       : res_r[SQRT_STAGES][15:0];

endmodule

/* rtl/frs_back.sv */
// Back end: divider, square root, fifth power and final blend to the outputs.
// Depends on frs_pkg, frs_div, frs_sqrt.
module frs_back import frs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  frs_job_t    job,
  output logic        out_valid,
  output logic [15:0] out_reflectance,
  output logic        out_total_internal,
  output logic        out_bad_index
);

  logic      div_vld, sq_vld;
  frs_quo_t  quo;
  frs_root_t root;

  frs_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (job_valid),
    .job    (job),
    .out_vld(div_vld),
    .quo    (quo)
  );

  frs_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_vld (div_vld),
    .quo    (quo),
    .out_vld(sq_vld),
    .root   (root)
  );

  logic [POW_STEPS+1:0] vld_r;
  logic [15:0] x_r   [POW_STEPS+1];
  logic [15:0] p_r   [POW_STEPS+1];
  logic [15:0] r0_r  [POW_STEPS+2];
  frs_tag_t    tag_r [POW_STEPS+2];
  logic [31:0] m_r;

  logic [15:0] c_sel;
  logic [16:0] sum;
  logic [15:0] refl;

  assign c_sel = root.tag.gt ? root.ct : root.tag.c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r     <= {vld_r[POW_STEPS:0], sq_vld};
      out_valid <= vld_r[POW_STEPS+1];
    end
  end

  always_ff @(posedge clk) begin
    logic [31:0] prod;
    x_r[0]   <= ONE_Q15 - c_sel;
    p_r[0]   <= ONE_Q15 - c_sel;
    r0_r[0]  <= root.r0;
    tag_r[0] <= root.tag;
    for (int k = 1; k <= POW_STEPS; k++) begin
      prod     = p_r[k-1] * x_r[k-1];
      p_r[k]   <= prod[30:15];
      x_r[k]   <= x_r[k-1];
      r0_r[k]  <= r0_r[k-1];
      tag_r[k] <= tag_r[k-1];
    end
    m_r                <= (ONE_Q15 - r0_r[POW_STEPS]) * p_r[POW_STEPS];
    r0_r[POW_STEPS+1]  <= r0_r[POW_STEPS];
    tag_r[POW_STEPS+1] <= tag_r[POW_STEPS];
  end

  always_comb begin
    sum  = 17'(r0_r[POW_STEPS+1]) + 17'(m_r[30:15]);
    refl = (sum > 17'(ONE_Q15)) ? ONE_Q15 : sum[15:0];
  end

  always_ff @(posedge clk) begin
    out_bad_index      <= tag_r[POW_STEPS+1].bad;
    out_total_internal <= !tag_r[POW_STEPS+1].bad && tag_r[POW_STEPS+1].tir;
    if (tag_r[POW_STEPS+1].bad) begin
      out_reflectance <= '0;
    end else if (tag_r[POW_STEPS+1].tir) begin
      out_reflectance <= ONE_Q15;
    end else begin
      out_reflectance <= refl;
    end
  end

endmodule

/* rtl/fresnel_reflectance_schlick.sv */
// Schlick Fresnel reflectance, top level: front end, job queue, back end.
// Throughput: one request per cycle.
// Rate is set by the fully pipelined 31-stage divider and 16-stage root.
// Results cannot be stalled, so the queue never fills and busy stays low.
// rst_n (synchronous, active low) clears all valid state; in-flight work is dropped.
module fresnel_reflectance_schlick import frs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_eye_x,
  input  logic signed [15:0] in_eye_y,
  input  logic signed [15:0] in_eye_z,
  input  logic signed [15:0] in_norm_x,
  input  logic signed [15:0] in_norm_y,
  input  logic signed [15:0] in_norm_z,
  input  logic        [15:0] in_index_from,
  input  logic        [15:0] in_index_to,
  output logic               out_valid,
  output logic        [15:0] out_reflectance,
  output logic               out_total_internal,
  output logic               out_bad_index
);

  logic     q_full, f_valid, b_valid;
  frs_job_t f_job, b_job;

  frs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_eye_x     (in_eye_x),
    .in_eye_y     (in_eye_y),
    .in_eye_z     (in_eye_z),
    .in_norm_x    (in_norm_x),
    .in_norm_y    (in_norm_y),
    .in_norm_z    (in_norm_z),
    .in_index_from(in_index_from),
    .in_index_to  (in_index_to),
    .q_full       (q_full),
    .job_valid    (f_valid),
    .job          (f_job)
  );

  frs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (f_valid),
    .wr_data (f_job),
    .full    (q_full),
    .rd_valid(b_valid),
    .rd_data (b_job)
  );

  frs_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (b_valid),
    .job               (b_job),
    .out_valid         (out_valid),
    .out_reflectance   (out_reflectance),
    .out_total_internal(out_total_internal),
    .out_bad_index     (out_bad_index)
  );

endmodule

/* rtl/frs_checker.sv */
// Port-level checks for fresnel_reflectance_schlick, bound to the top level.
// No package dependency.
module frs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic [15:0] out_reflectance,
  input logic        out_total_internal,
  input logic        out_bad_index
);

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_index |-> out_reflectance == 16'd0 && !out_total_internal)
    else $error("bad index result not zero");

  a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_total_internal |-> out_reflectance == 16'h8000)
    else $error("TIR result not 1.0");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_reflectance <= 16'h8000)
    else $error("reflectance above 1.0");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

endmodule

bind fresnel_reflectance_schlick frs_checker u_frs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_reflectance   (out_reflectance),
  .out_total_internal(out_total_internal),
  .out_bad_index     (out_bad_index)
);
